// File: hw/rtl/pcvd_pkg.sv
// ----------------------------------------------------------------------------
// pcvd_pkg: shared types and constants
// Item structs, divider handshake structs and register defaults.
// ----------------------------------------------------------------------------
package pcvd_pkg;

	localparam int unsigned AXES      = 3;
	localparam int unsigned CFG_W     = 31;
	localparam int unsigned DIV_W     = 64;
	localparam int unsigned STEP_W    = 7;

	localparam logic [CFG_W-1:0] BOX_RESET  = 31'd65536000;
	localparam logic [CFG_W-1:0] MASS_RESET = 31'd65536;
	localparam logic [CFG_W-1:0] GID_RESET  = 31'd0;

	// floor(x/5) = (x * RECIP5) >> 34 for any 32-bit x
	localparam logic [31:0] RECIP5 = 32'hCCCC_CCCD;

	// register indexes
	localparam logic [1:0] REG_BOX  = 2'd0;
	localparam logic [1:0] REG_MASS = 2'd1;
	localparam logic [1:0] REG_GID  = 2'd2;
	localparam logic [1:0] REG_NONE = 2'd3;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
		logic               last_in_group;
	} in_item_t;

	typedef struct packed {
		logic [31:0]        group_id;
		logic [24:0]        particle_count;
		logic [54:0]        total_mass;
		logic signed [31:0] com_x;
		logic signed [31:0] com_y;
		logic signed [31:0] com_z;
		logic signed [31:0] mean_vel_x;
		logic signed [31:0] mean_vel_y;
		logic signed [31:0] mean_vel_z;
		logic [31:0]        vel_dispersion;
		logic               periodic_used;
	} out_item_t;

	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_rsp_t;

endpackage

// File: hw/rtl/pcvd_div.sv
// ----------------------------------------------------------------------------
// pcvd_div: serial restoring divider
// Unsigned, one quotient bit per cycle; dividend enters left-aligned and the
// low "steps" bits of the quotient register hold the result.
// ----------------------------------------------------------------------------
module pcvd_div #(
	parameter int unsigned CW = 25
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pcvd_pkg::div_req_t            req,
	input  logic [pcvd_pkg::DIV_W-1:0]    dividend,
	input  logic [CW-1:0]                 divisor,
	output pcvd_pkg::div_rsp_t            rsp,
	output logic [pcvd_pkg::DIV_W-1:0]    quotient
);

	logic [CW-1:0]                      rem_q;
	logic [CW-1:0]                      dvs_q;
	logic [pcvd_pkg::DIV_W-1:0]         quo_q;
	logic [pcvd_pkg::STEP_W-1:0]        cnt_q;
	logic                               busy_q;
	logic                               done_q;
	logic [CW:0]                        trial;
	logic                               ge;

	always_comb begin
		trial = {rem_q, quo_q[pcvd_pkg::DIV_W-1]};
		ge    = (trial >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == pcvd_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? CW'(trial - {1'b0, dvs_q}) : CW'(trial);
			quo_q <= {quo_q[pcvd_pkg::DIV_W-2:0], ge};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign quotient = quo_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider restarted while busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q && $past(busy_q))
		else $error("divider done without a finished run");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("divider done held longer than one cycle");

endmodule

// File: hw/rtl/periodic_com_velocity_dispersion.sv
// ----------------------------------------------------------------------------
// periodic_com_velocity_dispersion: per-group centre of mass and dispersion
// Running Welford means of position and velocity per axis, with periodic
// unwrap of position steps, and a velocity dispersion on the last particle.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------
//  in      | to block  | in_valid / in_stall   | in_item  (pcvd_pkg::in_item_t)
//  out     | from blk  | out_valid / out_stall | out_item (pcvd_pkg::out_item_t)
//  cfg     | to block  | cfg_we                | cfg_index, cfg_data
//
//  For each particle, per axis, two 34-bit quotients come from the shared
//  serial divider (one bit per cycle), followed by a two-part product and
//  saturating add. The last particle of a group adds three 64-bit
//  quotients, 32 square root steps and the mass product before the result
//  is offered.
//  in_stall is low only while the sequencer waits for an item.
//  Reset clears all accumulators and the group counter; no clearing pass.
//  A stalled result waits in the output register; the next one is only
//  loaded once it has been taken.
// ----------------------------------------------------------------------------
module periodic_com_velocity_dispersion #(
	parameter int unsigned MAX_PARTICLES = 16777216
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  pcvd_pkg::in_item_t    in_item,
	output logic                  out_valid,
	input  logic                  out_stall,
	output pcvd_pkg::out_item_t   out_item,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [30:0]           cfg_data
);

	// count width: must hold MAX_PARTICLES itself
	localparam int unsigned CW = $clog2(MAX_PARTICLES + 1);

	typedef enum logic [14:0] {
		S_IDLE     = 15'b000000000000001,
		S_POS_GO   = 15'b000000000000010,
		S_POS_WAIT = 15'b000000000000100,
		S_VEL_GO   = 15'b000000000001000,
		S_VEL_WAIT = 15'b000000000010000,
		S_PREP     = 15'b000000000100000,
		S_MUL_A    = 15'b000000001000000,
		S_MUL_B    = 15'b000000010000000,
		S_SUMP     = 15'b000000100000000,
		S_ACC      = 15'b000001000000000,
		S_DEV_GO   = 15'b000010000000000,
		S_DEV_WAIT = 15'b000100000000000,
		S_SQRT     = 15'b001000000000000,
		S_MASS     = 15'b010000000000000,
		S_EMIT     = 15'b100000000000000
	} state_t;

	state_t state_q;

	// configuration
	logic [30:0] box_q, mass_q, gid_q;
	logic [28:0] lim_q;
	logic [62:0] recip_prod;

	// group accumulators
	logic signed [31:0] mp_q  [pcvd_pkg::AXES];
	logic signed [31:0] mv_q  [pcvd_pkg::AXES];
	logic        [63:0] dev_q [pcvd_pkg::AXES];
	logic [CW-1:0]      seen_q;
	logic               wrap_q;
	logic [31:0]        gidx_q;

	// latched item
	logic signed [31:0] pos_q [pcvd_pkg::AXES];
	logic signed [31:0] vel_q [pcvd_pkg::AXES];
	logic               last_q;
	logic [1:0]         axis_q;

	// datapath registers
	logic               sign_q;
	logic signed [33:0] dv_q;
	logic [32:0]        amag_q;
	logic [32:0]        rest_q;
	logic [49:0]        plo_q;
	logic [48:0]        phi_q;
	logic [63:0]        prod_q;
	logic [63:0]        var_q;
	logic [63:0]        sqv_q, sqr_q, sqb_q;
	logic [CW+30:0]     gmass_q;

	// output register
	logic                out_valid_q;
	pcvd_pkg::out_item_t out_q;

	// divider
	pcvd_pkg::div_req_t           div_req;
	pcvd_pkg::div_rsp_t           div_rsp;
	logic [pcvd_pkg::DIV_W-1:0]   div_dividend;
	logic [CW-1:0]                div_divisor;
	logic [pcvd_pkg::DIV_W-1:0]   div_quo;

	pcvd_div #(.CW(CW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.rsp      (div_rsp),
		.quotient (div_quo)
	);

	// combinational temporaries
	logic signed [34:0] del_a, del_b, del_c, lim_s, box_s, del_mag;
	logic               wrap_hit;
	logic signed [34:0] qs;
	logic signed [35:0] psum;
	logic signed [31:0] mp_new;
	logic signed [33:0] dv, dv_mag, rest;
	logic [64:0]        dev_sum, var_sum;
	logic [63:0]        dev_new, var_new, sq_t;
	logic               emit_go, accept;
	logic [CW-1:0]      cnt_next;
	logic signed [33:0] com_c [pcvd_pkg::AXES];
	logic signed [31:0] com_o [pcvd_pkg::AXES];

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		logic signed [35:0] hi, lo;
		hi = 36'sh0_7FFF_FFFF;
		lo = -36'sh0_8000_0000;
		if (v > hi)
			return 32'sh7FFF_FFFF;
		else if (v < lo)
			return 32'sh8000_0000;
		else
			return v[31:0];
	endfunction

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign cnt_next = seen_q + 1'b1;
	assign emit_go  = (state_q == S_EMIT) && (!out_valid_q || !out_stall);
	assign recip_prod = 63'(box_q) * 63'(pcvd_pkg::RECIP5);

	always_comb begin
		// position step, unwrapped by one box length either way
		lim_s    = 35'(lim_q);
		box_s    = 35'(box_q);
		del_a    = 35'(pos_q[axis_q]) - 35'(mp_q[axis_q]);
		wrap_hit = 1'b0;
		del_b    = del_a;
		if (seen_q != '0 && del_a > lim_s) begin
			del_b    = del_a - box_s;
			wrap_hit = 1'b1;
		end
		del_c = del_b;
		if (seen_q != '0 && del_b < -lim_s) begin
			del_c    = del_b + box_s;
			wrap_hit = 1'b1;
		end
		del_mag = del_c[34] ? -del_c : del_c;

		// signed quotient, truncated toward zero
		qs     = sign_q ? -$signed({1'b0, div_quo[33:0]}) : $signed({1'b0, div_quo[33:0]});
		psum   = 36'(mp_q[axis_q]) + 36'(qs);
		mp_new = sat32(psum);

		dv     = 34'(vel_q[axis_q]) - 34'(mv_q[axis_q]);
		dv_mag = dv[33] ? -dv : dv;

		// deviation after the mean update, folded to the sign of dv
		rest = 34'(vel_q[axis_q]) - 34'(mv_q[axis_q]);
		if (dv_q[33])
			rest = -rest;
		if (rest[33])
			rest = '0;

		dev_sum = 65'(dev_q[axis_q]) + 65'(prod_q);
		dev_new = dev_sum[64] ? '1 : dev_sum[63:0];
		var_sum = 65'(var_q) + 65'(div_quo);
		var_new = var_sum[64] ? '1 : var_sum[63:0];

		sq_t = sqr_q + sqb_q;

		for (int k = 0; k < pcvd_pkg::AXES; k++) begin
			com_c[k] = 34'(mp_q[k]);
			if (wrap_q) begin
				if (com_c[k] < 0)
					com_c[k] = com_c[k] + 34'(box_q);
				if (com_c[k] > $signed(34'(box_q)))
					com_c[k] = com_c[k] - 34'(box_q);
			end
			com_o[k] = sat32(36'(com_c[k]));
		end
	end

	// divider operands: particle steps use 34 quotient bits, group end 64
	always_comb begin
		div_req.start = 1'b0;
		div_req.steps = pcvd_pkg::STEP_W'(34);
		div_dividend  = {del_mag[33:0], 30'd0};
		div_divisor   = cnt_next;
		priority case (1'b1)
			state_q == S_POS_GO: begin
				div_req.start = 1'b1;
			end
			state_q == S_VEL_GO: begin
				div_req.start = 1'b1;
				div_dividend  = {dv_mag[33:0], 30'd0};
			end
			state_q == S_DEV_GO: begin
				div_req.start = 1'b1;
				div_req.steps = pcvd_pkg::STEP_W'(64);
				div_dividend  = dev_q[axis_q];
				div_divisor   = seen_q;
			end
			default: begin
			end
		endcase
	end

	// configuration registers; lim is registered from box and follows it in the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q  <= pcvd_pkg::BOX_RESET;
			mass_q <= pcvd_pkg::MASS_RESET;
			gid_q  <= pcvd_pkg::GID_RESET;
			lim_q  <= 29'(pcvd_pkg::BOX_RESET / 5);
		end else begin
			lim_q <= recip_prod[62:34];
			if (cfg_we) begin
				unique case (cfg_index)
					pcvd_pkg::REG_BOX:  box_q  <= cfg_data;
					pcvd_pkg::REG_MASS: mass_q <= cfg_data;
					pcvd_pkg::REG_GID:  gid_q  <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	// sequencer and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			axis_q  <= '0;
			seen_q  <= '0;
			wrap_q  <= 1'b0;
			gidx_q  <= '0;
			for (int k = 0; k < pcvd_pkg::AXES; k++) begin
				mp_q[k]  <= '0;
				mv_q[k]  <= '0;
				dev_q[k] <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						axis_q <= '0;
						if (seen_q < CW'(MAX_PARTICLES))
							state_q <= S_POS_GO;
						else if (in_item.last_in_group)
							state_q <= S_DEV_GO;
					end
				end
				S_POS_GO: begin
					if (wrap_hit)
						wrap_q <= 1'b1;
					state_q <= S_POS_WAIT;
				end
				S_POS_WAIT: begin
					if (div_rsp.done) begin
						mp_q[axis_q] <= mp_new;
						state_q      <= S_VEL_GO;
					end
				end
				S_VEL_GO: state_q <= S_VEL_WAIT;
				S_VEL_WAIT: begin
					if (div_rsp.done) begin
						mv_q[axis_q] <= mv_q[axis_q] + qs[31:0];
						state_q      <= S_PREP;
					end
				end
				S_PREP:  state_q <= S_MUL_A;
				S_MUL_A: state_q <= S_MUL_B;
				S_MUL_B: state_q <= S_SUMP;
				S_SUMP:  state_q <= S_ACC;
				S_ACC: begin
					dev_q[axis_q] <= dev_new;
					if (axis_q == 2'd2) begin
						seen_q <= cnt_next;
						axis_q <= '0;
						state_q <= last_q ? S_DEV_GO : S_IDLE;
					end else begin
						axis_q  <= axis_q + 1'b1;
						state_q <= S_POS_GO;
					end
				end
				S_DEV_GO: state_q <= S_DEV_WAIT;
				S_DEV_WAIT: begin
					if (div_rsp.done) begin
						if (axis_q == 2'd2) begin
							state_q <= S_SQRT;
						end else begin
							axis_q  <= axis_q + 1'b1;
							state_q <= S_DEV_GO;
						end
					end
				end
				S_SQRT: begin
					if (sqb_q == 64'd1)
						state_q <= S_MASS;
				end
				S_MASS: state_q <= S_EMIT;
				S_EMIT: begin
					// hand over the result, then clear for the next group
					if (emit_go) begin
						for (int k = 0; k < pcvd_pkg::AXES; k++) begin
							mp_q[k]  <= '0;
							mv_q[k]  <= '0;
							dev_q[k] <= '0;
						end
						seen_q  <= '0;
						wrap_q  <= 1'b0;
						gidx_q  <= gidx_q + 1'b1;
						axis_q  <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			pos_q[0] <= in_item.pos_x;
			pos_q[1] <= in_item.pos_y;
			pos_q[2] <= in_item.pos_z;
			vel_q[0] <= in_item.vel_x;
			vel_q[1] <= in_item.vel_y;
			vel_q[2] <= in_item.vel_z;
			last_q   <= in_item.last_in_group;
			var_q    <= '0;
		end
		if (state_q == S_POS_GO)
			sign_q <= del_c[34];
		if (state_q == S_VEL_GO) begin
			sign_q <= dv[33];
			dv_q   <= dv;
		end
		if (state_q == S_PREP) begin
			amag_q <= 33'(dv_q[33] ? -dv_q : dv_q);
			rest_q <= rest[32:0];
		end
		if (state_q == S_MUL_A)
			plo_q <= 50'(amag_q) * 50'(rest_q[16:0]);
		if (state_q == S_MUL_B)
			phi_q <= 49'(amag_q) * 49'(rest_q[32:17]);
		if (state_q == S_SUMP)
			prod_q <= 64'(plo_q) + {phi_q[46:0], 17'd0};
		if (state_q == S_ACC)
			var_q <= '0;
		if (state_q == S_DEV_WAIT && div_rsp.done) begin
			var_q <= var_new;
			if (axis_q == 2'd2) begin
				sqv_q <= var_new;
				sqr_q <= '0;
				sqb_q <= 64'h4000_0000_0000_0000;
			end
		end
		if (state_q == S_SQRT) begin
			// one digit of the integer square root per cycle
			if (sqv_q >= sq_t) begin
				sqv_q <= sqv_q - sq_t;
				sqr_q <= (sqr_q >> 1) + sqb_q;
			end else begin
				sqr_q <= sqr_q >> 1;
			end
			sqb_q <= sqb_q >> 2;
		end
		if (state_q == S_MASS)
			gmass_q <= (CW+31)'(seen_q) * (CW+31)'(mass_q);
		if (emit_go) begin
			out_q.group_id       <= 32'(gid_q) + gidx_q;
			out_q.particle_count <= 25'(seen_q);
			out_q.total_mass     <= 55'(gmass_q);
			out_q.com_x          <= com_o[0];
			out_q.com_y          <= com_o[1];
			out_q.com_z          <= com_o[2];
			out_q.mean_vel_x     <= mv_q[0];
			out_q.mean_vel_y     <= mv_q[1];
			out_q.mean_vel_z     <= mv_q[2];
			out_q.vel_dispersion <= sqr_q[31:0];
			out_q.periodic_used  <= wrap_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit_go)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	a_clear_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		emit_go |=> seen_q == '0 && !wrap_q && state_q == S_IDLE)
		else $error("group state not cleared after result");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= CW'(MAX_PARTICLES))
		else $error("particle count beyond limit");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(out_q))
		else $error("pending result lost");

	a_div_idle_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !div_rsp.busy)
		else $error("item taken while divider running");

endmodule
